// ===== src/lcar_pkg.sv =====
`timescale 1ns / 1ps

package lcar_pkg;

   // Defaults for the top-level parameters
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int MAX_AVERAGE_DEF = 255;

   // Fixed field and register widths
   localparam int WORD_W = 24;
   localparam int NET_W  = 25;
   localparam int SUM_W  = 32;
   localparam int CNT_W  = 8;
   localparam int HALF_W = 8;
   localparam int GAIN_W = 2;
   localparam int ACT_W  = 2;
   localparam int KIND_W = 2;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [WORD_W-1:0] SIGN_FLIP  = 24'h800000;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 2'd1;
   localparam logic [HALF_W-1:0] HALF_RESET = 8'd16;

   // Action codes
   localparam logic [ACT_W-1:0] ACT_TICK    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_AVERAGE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TARE    = 2'd2;
   localparam logic [ACT_W-1:0] ACT_NET     = 2'd3;

   // Completion kinds
   localparam logic [KIND_W-1:0] KIND_AVERAGE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TARE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NET     = 2'd2;

   // Register index, taken from paddr bit 2
   localparam logic REG_GAIN = 1'b0;
   localparam logic REG_HALF = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT,
      PH_HIGH,
      PH_LOW,
      PH_DIV_LOAD,
      PH_DIV_RUN,
      PH_FINISH
   } phase_type;

   typedef struct packed {
      logic start;
      logic conv_start;
      logic timer_step;
      logic sample;
      logic accumulate;
      logic div_start;
      logic emit_tick;
      logic emit_final;
      logic tick_clock;
      logic tick_busy;
   } cmd_type;

   typedef struct packed {
      logic timer_expired;
      logic bits_more;
      logic reads_more;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

// ===== src/lcar_req_if.sv =====
`timescale 1ns / 1ps

interface lcar_req_if import lcar_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [CNT_W-1:0]  sample_count;
   logic              data_level;

   modport source (output valid, action, sample_count, data_level, input ready);
   modport sink   (input valid, action, sample_count, data_level, output ready);
endinterface

// ===== src/lcar_rsp_if.sv =====
`timescale 1ns / 1ps

interface lcar_rsp_if import lcar_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     clock_level;
   logic                     busy_res;
   logic                     done_res;
   logic [WORD_W-1:0]        average_value;
   logic signed [NET_W-1:0]  net_value;
   logic [KIND_W-1:0]        done_kind;

   modport source (output valid, clock_level, busy_res, done_res, average_value,
                   net_value, done_kind, input ready);
   modport sink   (input valid, clock_level, busy_res, done_res, average_value,
                   net_value, done_kind, output ready);
endinterface

// ===== src/load_cell_adc_reader_tare.sv =====
`timescale 1ns / 1ps

// Load-cell bridge converter reader with averaging and tare. Each req word is
// one time tick carrying the sampled converter data line and an optional
// command (average, tare, net value) with a sample count; each tick returns
// exactly one rsp word with the serial clock level to drive, busy, and on the
// completing tick done with the mean, the net value and its kind. A command
// waits for the data line to go low, clocks in SAMPLE_BITS bits MSB first,
// sends gain_pulses extra clocks (0 counts as 1), flips bit 23 of the
// 24-bit reading, and repeats for the sample count (0 counts as 1, capped
// at MAX_AVERAGE). Commands that arrive while busy are ignored. Rate: one
// tick word per clock cycle while the rsp side takes words; the tick that
// closes the last conversion holds the req side while the bit-serial
// divider (32 steps, one quotient bit per cycle) forms the mean, then that
// tick's word follows. Registers at paddr 0 (gain_pulses) and 4
// (half_period_ticks), selected by paddr bit 2.
module load_cell_adc_reader_tare import lcar_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_AVERAGE = MAX_AVERAGE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   lcar_req_if.sink          req_ch,
   lcar_rsp_if.source        rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [HALF_W-1:0] half_ff, half_in;
   logic              csr_write;
   cmd_type           cmd;
   stat_type          stat;

   // Config port: zero wait states, write on the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      gain_in = gain_ff;
      half_in = half_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_GAIN: gain_in = csr_pwdata[GAIN_W-1:0];
            REG_HALF: half_in = csr_pwdata[HALF_W-1:0];
            default:  gain_in = gain_ff;
         endcase
      end
   end

   // Read back the selected register, zero-extended.
   always_comb begin
      unique case (csr_paddr[2])
         REG_GAIN: csr_prdata = CSR_DW'(gain_ff);
         REG_HALF: csr_prdata = CSR_DW'(half_ff);
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         half_ff <= HALF_RESET;
      end else begin
         gain_ff <= gain_in;
         half_ff <= half_in;
      end
   end

   // Sequencer: serial clock phases, conversion loop and divider handoff.
   lcar_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .action     (req_ch.action),
      .data_level (req_ch.data_level),
      .stat       (stat),
      .req_ready  (req_ch.ready),
      .cmd        (cmd)
   );

   // Timers, shift register, accumulator, tare offset, divider, rsp register.
   lcar_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_AVERAGE (MAX_AVERAGE)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .action            (req_ch.action),
      .sample_count      (req_ch.sample_count),
      .data_level        (req_ch.data_level),
      .gain_pulses       (gain_ff),
      .half_period_ticks (half_ff),
      .rsp               (rsp_ch)
   );

endmodule

// ===== src/lcar_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module lcar_divider import lcar_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // borrow out means the trial stays below the divisor
         if (diff[CNT_W]) begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end else begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/lcar_datapath.sv =====
`timescale 1ns / 1ps

module lcar_datapath import lcar_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_AVERAGE = MAX_AVERAGE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [ACT_W-1:0]  action,
   input  logic [CNT_W-1:0]  sample_count,
   input  logic              data_level,
   input  logic [GAIN_W-1:0] gain_pulses,
   input  logic [HALF_W-1:0] half_period_ticks,
   lcar_rsp_if.source        rsp
);

   localparam int BIT_W = $clog2(SAMPLE_BITS + 4);

   logic [HALF_W-1:0]  timer_ff, timer_in;
   logic [BIT_W-1:0]   bits_ff, bits_in;
   logic [WORD_W-1:0]  shift_ff, shift_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   reads_ff, reads_in;
   logic [CNT_W-1:0]   target_ff, target_in;
   logic [ACT_W-1:0]   pending_ff, pending_in;
   logic [WORD_W-1:0]  tare_ff, tare_in;
   logic               out_valid_ff, out_valid_in;

   logic               out_clock_ff, out_clock_in;
   logic               out_busy_ff, out_busy_in;
   logic               out_done_ff, out_done_in;
   logic [WORD_W-1:0]  out_avg_ff, out_avg_in;
   logic [NET_W-1:0]   out_net_ff, out_net_in;
   logic [KIND_W-1:0]  out_kind_ff, out_kind_in;

   logic [HALF_W-1:0]  half_eff;
   logic [GAIN_W-1:0]  extra;
   logic [BIT_W-1:0]   total;
   logic [HALF_W:0]    timer_inc;
   logic               expired;
   logic [WORD_W-1:0]  shift_next;
   logic [CNT_W-1:0]   count_eff;
   logic [WORD_W-1:0]  avg;
   logic [WORD_W-1:0]  tare_final;
   logic [KIND_W-1:0]  kind;
   logic               div_done;
   logic [SUM_W-1:0]   div_quo;

   lcar_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (target_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      half_eff   = (half_period_ticks == '0) ? HALF_W'(1) : half_period_ticks;
      extra      = (gain_pulses == '0) ? GAIN_W'(1) : gain_pulses;
      total      = BIT_W'(SAMPLE_BITS) + BIT_W'(extra);
      timer_inc  = {1'b0, timer_ff} + 1'b1;
      expired    = timer_inc >= {1'b0, half_eff};
      shift_next = (bits_ff < BIT_W'(SAMPLE_BITS)) ? {shift_ff[WORD_W-2:0], data_level}
                                                    : shift_ff;
      if (sample_count == '0) begin
         count_eff = CNT_W'(1);
      end else if (sample_count > CNT_W'(MAX_AVERAGE)) begin
         count_eff = CNT_W'(MAX_AVERAGE);
      end else begin
         count_eff = sample_count;
      end
      avg        = div_quo[WORD_W-1:0];
      tare_final = (pending_ff == ACT_TARE) ? avg : tare_ff;
      case (pending_ff)
         ACT_TARE: kind = KIND_TARE;
         ACT_NET:  kind = KIND_NET;
         default:  kind = KIND_AVERAGE;
      endcase
   end

   always_comb begin
      stat.timer_expired = expired;
      stat.bits_more     = (bits_ff + 1'b1) < total;
      stat.reads_more    = ({1'b0, reads_ff} + 1'b1) < {1'b0, target_ff};
      stat.div_done      = div_done;
      stat.out_free      = !out_valid_ff || rsp.ready;
   end

   always_comb begin
      timer_in   = timer_ff;
      bits_in    = bits_ff;
      shift_in   = shift_ff;
      sum_in     = sum_ff;
      reads_in   = reads_ff;
      target_in  = target_ff;
      pending_in = pending_ff;
      tare_in    = tare_ff;
      if (cmd.start) begin
         pending_in = action;
         target_in  = count_eff;
         reads_in   = '0;
         sum_in     = '0;
      end
      if (cmd.conv_start) begin
         timer_in = '0;
         bits_in  = '0;
         shift_in = '0;
      end
      if (cmd.timer_step) begin
         timer_in = expired ? '0 : timer_inc[HALF_W-1:0];
      end
      if (cmd.sample) begin
         shift_in = shift_next;
         bits_in  = bits_ff + 1'b1;
      end
      if (cmd.accumulate) begin
         sum_in   = sum_ff + SUM_W'(shift_next ^ SIGN_FLIP);
         reads_in = reads_ff + 1'b1;
      end
      if (cmd.emit_final) begin
         tare_in = tare_final;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      out_clock_in = out_clock_ff;
      out_busy_in  = out_busy_ff;
      out_done_in  = out_done_ff;
      out_avg_in   = out_avg_ff;
      out_net_in   = out_net_ff;
      out_kind_in  = out_kind_ff;
      if (cmd.emit_tick) begin
         out_valid_in = 1'b1;
         out_clock_in = cmd.tick_clock;
         out_busy_in  = cmd.tick_busy;
         out_done_in  = 1'b0;
         out_avg_in   = '0;
         out_net_in   = '0;
         out_kind_in  = KIND_AVERAGE;
      end else if (cmd.emit_final) begin
         out_valid_in = 1'b1;
         out_clock_in = 1'b0;
         out_busy_in  = 1'b0;
         out_done_in  = 1'b1;
         out_avg_in   = avg;
         out_net_in   = {1'b0, avg} - {1'b0, tare_final};
         out_kind_in  = kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff     <= '0;
         bits_ff      <= '0;
         shift_ff     <= '0;
         sum_ff       <= '0;
         reads_ff     <= '0;
         target_ff    <= CNT_W'(1);
         pending_ff   <= ACT_TICK;
         tare_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         timer_ff     <= timer_in;
         bits_ff      <= bits_in;
         shift_ff     <= shift_in;
         sum_ff       <= sum_in;
         reads_ff     <= reads_in;
         target_ff    <= target_in;
         pending_ff   <= pending_in;
         tare_ff      <= tare_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_clock_ff <= out_clock_in;
      out_busy_ff  <= out_busy_in;
      out_done_ff  <= out_done_in;
      out_avg_ff   <= out_avg_in;
      out_net_ff   <= out_net_in;
      out_kind_ff  <= out_kind_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.clock_level   = out_clock_ff;
   assign rsp.busy_res      = out_busy_ff;
   assign rsp.done_res      = out_done_ff;
   assign rsp.average_value = out_avg_ff;
   assign rsp.net_value     = out_net_ff;
   assign rsp.done_kind     = out_kind_ff;

endmodule

// ===== src/lcar_controller.sv =====
`timescale 1ns / 1ps

module lcar_controller import lcar_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [ACT_W-1:0] action,
   input  logic             data_level,
   input  stat_type         stat,
   output logic             req_ready,
   output cmd_type          cmd
);

   phase_type phase_ff, phase_in;
   logic      fire;
   logic      conv_end;
   logic      cmd_end;

   assign req_ready = (phase_ff == PH_IDLE || phase_ff == PH_WAIT ||
                       phase_ff == PH_HIGH || phase_ff == PH_LOW) && stat.out_free;
   assign fire      = req_valid && req_ready;
   assign conv_end  = stat.timer_expired && !stat.bits_more;
   assign cmd_end   = conv_end && !stat.reads_more;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (fire && action != ACT_TICK) phase_in = PH_WAIT;
         end
         PH_WAIT: begin
            if (fire && !data_level) phase_in = PH_HIGH;
         end
         PH_HIGH: begin
            if (fire && stat.timer_expired) phase_in = PH_LOW;
         end
         PH_LOW: begin
            if (fire && stat.timer_expired) begin
               if (stat.bits_more) phase_in = PH_HIGH;
               else if (stat.reads_more) phase_in = PH_WAIT;
               else phase_in = PH_DIV_LOAD;
            end
         end
         PH_DIV_LOAD: phase_in = PH_DIV_RUN;
         PH_DIV_RUN: begin
            if (stat.div_done) phase_in = PH_FINISH;
         end
         PH_FINISH: begin
            if (stat.out_free) phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.tick_clock = (phase_in == PH_HIGH);
      cmd.tick_busy  = (phase_in != PH_IDLE);
      unique case (phase_ff)
         PH_IDLE: begin
            cmd.emit_tick = fire;
            cmd.start     = fire && action != ACT_TICK;
         end
         PH_WAIT: begin
            cmd.emit_tick  = fire;
            cmd.conv_start = fire && !data_level;
         end
         PH_HIGH: begin
            cmd.emit_tick  = fire;
            cmd.timer_step = fire;
         end
         PH_LOW: begin
            // hold back the word of the closing tick until the mean is ready
            cmd.emit_tick  = fire && !cmd_end;
            cmd.timer_step = fire;
            cmd.sample     = fire && stat.timer_expired;
            cmd.accumulate = fire && conv_end;
         end
         PH_DIV_LOAD: cmd.div_start  = 1'b1;
         PH_DIV_RUN:  cmd.div_start  = 1'b0;
         PH_FINISH:   cmd.emit_final = stat.out_free;
         default:     cmd.emit_tick  = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== src/lcar_checker.sv =====
`timescale 1ns / 1ps

module lcar_checker import lcar_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_clock_level,
   input logic                    rsp_busy_res,
   input logic                    rsp_done_res,
   input logic [WORD_W-1:0]       rsp_average_value,
   input logic signed [NET_W-1:0] rsp_net_value,
   input logic [KIND_W-1:0]       rsp_done_kind
);

   // no word survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_done_res) &&
      $stable(rsp_average_value) && $stable(rsp_net_value) && $stable(rsp_done_kind))
      else $error("stalled rsp word changed");

   // completion returns the block to idle with the clock low
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_clock_level)
      else $error("done word while busy or clock high");

   // result fields are zero on plain tick words
   a_tick_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |->
      rsp_average_value == '0 && rsp_net_value == '0 && rsp_done_kind == KIND_AVERAGE)
      else $error("tick word carries result fields");

   // a tare reports zero net
   a_tare_net: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_done_kind == KIND_TARE |-> rsp_net_value == '0)
      else $error("tare with nonzero net");

endmodule

bind load_cell_adc_reader_tare lcar_checker u_lcar_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_clock_level   (rsp_ch.clock_level),
   .rsp_busy_res      (rsp_ch.busy_res),
   .rsp_done_res      (rsp_ch.done_res),
   .rsp_average_value (rsp_ch.average_value),
   .rsp_net_value     (rsp_ch.net_value),
   .rsp_done_kind     (rsp_ch.done_kind)
);

// ===== tb/sv/lcar_tare_checker.sv =====
`timescale 1ns / 1ps

module lcar_tare_checker import lcar_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   lcar_req_if               req_mon,
   lcar_rsp_if               rsp_mon,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   input  logic              csr_pready,
   output int                error_count,
   output int                open_ticks
);

   typedef struct packed {
      logic              clock_level;
      logic              busy;
      logic              done;
      logic [WORD_W-1:0] average;
      logic [NET_W-1:0]  net;
      logic [KIND_W-1:0] kind;
   } tick_word_type;

   logic [GAIN_W-1:0] gain_cfg;
   logic [HALF_W-1:0] half_cfg;
   phase_type         seq_phase;
   logic [ACT_W-1:0]  command;
   logic [HALF_W-1:0] level_timer;
   int                bits_in;
   logic [WORD_W-1:0] shift_reg;
   logic [SUM_W-1:0]  reading_sum;
   logic [CNT_W-1:0]  reads_done;
   logic [CNT_W-1:0]  reads_target;
   logic [WORD_W-1:0] tare_offset;
   tick_word_type     tick_results[$];

   // Advance the serial reader by one tick and return the word it should emit.
   function automatic tick_word_type reader_tick(input logic [ACT_W-1:0] act,
                                                 input logic [CNT_W-1:0] cnt,
                                                 input logic level);
      tick_word_type     w;
      logic [HALF_W-1:0] half;
      int                total_pulses;
      int                n;
      w = '0;
      half = (half_cfg == '0) ? HALF_W'(1) : half_cfg;
      total_pulses = SAMPLE_BITS_DEF + ((gain_cfg == '0) ? 1 : int'(gain_cfg));
      case (seq_phase)
         PH_IDLE: begin
            if (act != ACT_TICK) begin
               n = (cnt == '0) ? 1 : int'(cnt);
               if (n > MAX_AVERAGE_DEF) n = MAX_AVERAGE_DEF;
               command = act;
               reads_target = CNT_W'(n);
               reads_done = '0;
               reading_sum = '0;
               seq_phase = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (!level) begin
               seq_phase = PH_HIGH;
               level_timer = '0;
               bits_in = 0;
               shift_reg = '0;
            end
         end
         PH_HIGH: begin
            level_timer = level_timer + 1'b1;
            if (level_timer >= half) begin
               seq_phase = PH_LOW;
               level_timer = '0;
            end
         end
         default: begin
            level_timer = level_timer + 1'b1;
            if (level_timer >= half) begin
               level_timer = '0;
               // sample at the end of each low level, gain pulses shift nothing
               if (bits_in < SAMPLE_BITS_DEF) shift_reg = {shift_reg[WORD_W-2:0], level};
               bits_in++;
               if (bits_in < total_pulses) begin
                  seq_phase = PH_HIGH;
               end else begin
                  reading_sum = reading_sum + SUM_W'(shift_reg ^ SIGN_FLIP);
                  reads_done = reads_done + 1'b1;
                  if (reads_done < reads_target) begin
                     seq_phase = PH_WAIT;
                  end else begin
                     w.average = WORD_W'(reading_sum / SUM_W'(reads_target));
                     if (command == ACT_TARE) begin
                        tare_offset = w.average;
                        w.kind = KIND_TARE;
                     end else if (command == ACT_NET) begin
                        w.kind = KIND_NET;
                     end else begin
                        w.kind = KIND_AVERAGE;
                     end
                     w.net = {1'b0, w.average} - {1'b0, tare_offset};
                     w.done = 1'b1;
                     seq_phase = PH_IDLE;
                  end
               end
            end
         end
      endcase
      w.clock_level = (seq_phase == PH_HIGH);
      w.busy = (seq_phase != PH_IDLE);
      return w;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      tick_word_type want_w;
      tick_word_type got_w;
      if (reset) begin
         gain_cfg = GAIN_RESET;
         half_cfg = HALF_RESET;
         seq_phase = PH_IDLE;
         command = ACT_TICK;
         level_timer = '0;
         bits_in = 0;
         shift_reg = '0;
         reading_sum = '0;
         reads_done = '0;
         reads_target = CNT_W'(1);
         tare_offset = '0;
         tick_results.delete();
         error_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[2])
               REG_GAIN: gain_cfg = csr_pwdata[GAIN_W-1:0];
               REG_HALF: half_cfg = csr_pwdata[HALF_W-1:0];
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            tick_results.push_back(reader_tick(req_mon.action, req_mon.sample_count,
                                               req_mon.data_level));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_w.clock_level = rsp_mon.clock_level;
            got_w.busy = rsp_mon.busy_res;
            got_w.done = rsp_mon.done_res;
            got_w.average = rsp_mon.average_value;
            got_w.net = rsp_mon.net_value;
            got_w.kind = rsp_mon.done_kind;
            if (tick_results.size() == 0) begin
               $error("rsp word arrived with no tick outstanding");
               error_count++;
            end else begin
               want_w = tick_results.pop_front();
               check_field("clock_level", want_w.clock_level, got_w.clock_level);
               check_field("busy_res", want_w.busy, got_w.busy);
               check_field("done_res", want_w.done, got_w.done);
               check_field("average_value", want_w.average, got_w.average);
               check_field("net_value", want_w.net, got_w.net);
               check_field("done_kind", want_w.kind, got_w.kind);
            end
         end
      end
      open_ticks = tick_results.size();
   end

endmodule

// ===== tb/sv/tb_load_cell_adc_reader_tare.sv =====
`timescale 1ns / 1ps

module tb_load_cell_adc_reader_tare;
   import lcar_pkg::*;

   // Converter data line behavior, chosen per command
   localparam int LINE_LOW    = 0;   // all zero bits, reading 0x800000
   localparam int LINE_HIGHISH = 1;  // mostly ones, long waits for the line to drop
   localparam int LINE_NOISE  = 2;   // fair random bits
   localparam int LINE_LOWISH = 3;   // mostly zeros

   // Tick words to send in the whole run
   localparam int ITEMS = 450;

   bit                clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   lcar_req_if req_ch ();
   lcar_rsp_if rsp_ch ();

   int   error_count;
   int   open_ticks;
   int   ticks_sent;      // req words accepted
   int   words_taken;     // rsp words accepted
   logic last_busy;       // busy flag of the newest rsp word
   int   command_mark;    // ticks_sent right after the newest command word
   int   data_mode = LINE_NOISE;
   bit   calm = 1'b0;     // set near the end: no gaps, no stalls
   int   stall_left = 0;

   load_cell_adc_reader_tare uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lcar_tare_checker tick_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .error_count (error_count),
      .open_ticks  (open_ticks)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Count words on both channels so the stimulus knows when the reader is idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_sent <= 0;
         words_taken <= 0;
         last_busy <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) ticks_sent <= ticks_sent + 1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_taken <= words_taken + 1;
            last_busy <= rsp_ch.busy_res;
         end
      end
   end

   // Stall the rsp side in random bursts; hold ready high once calm.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Level the converter drives on its data line for the next tick.
   function automatic logic line_level();
      case (data_mode)
         LINE_LOW:     return 1'b0;
         LINE_HIGHISH: return ($urandom_range(0, 15) != 0);
         LINE_LOWISH:  return ($urandom_range(0, 15) == 0);
         default:      return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // Offer one tick word, maybe after a random gap; return at the negedge after acceptance.
   task automatic send_tick(input logic [ACT_W-1:0] act, input logic [CNT_W-1:0] cnt,
                            input logic level);
      if (!calm && $urandom_range(0, 15) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.sample_count <= cnt;
      req_ch.data_level <= level;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Two-phase register write: setup cycle, then access cycle.
   task automatic csr_write(input logic reg_sel, input logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic configure(input int gain, input int half);
      csr_write(REG_GAIN, CSR_DW'(gain));
      csr_write(REG_HALF, CSR_DW'(half));
   endtask

   // Keep ticking until a word issued after the last command shows the reader idle,
   // then hold the req side until every tick word has come back.
   task automatic settle();
      while (!(words_taken > command_mark && !last_busy))
         send_tick(ACT_TICK, CNT_W'($urandom_range(0, 255)), line_level());
      req_ch.valid <= 1'b0;
      while (words_taken != ticks_sent) @(negedge clock);
   endtask

   task automatic run_command(input logic [ACT_W-1:0] act, input int cnt, input int mode);
      data_mode = mode;
      send_tick(act, CNT_W'(cnt), line_level());
      command_mark = ticks_sent;
      settle();
   endtask

   // Mostly single or double conversions; now and then a short average.
   function automatic int pick_count();
      if ($urandom_range(0, 7) == 0) return $urandom_range(3, 4);
      return $urandom_range(0, 2);
   endfunction

   initial begin
      int goal;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_TICK;
      req_ch.sample_count = '0;
      req_ch.data_level = 1'b1;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      command_mark = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Gain and half period fields of zero both run as one; count zero acts as one.
      configure(0, 0);
      run_command(ACT_AVERAGE, 0, LINE_LOW);

      // Three gain pulses: tare at the zero reading, then a net below it.
      configure(3, 1);
      run_command(ACT_TARE, 1, LINE_LOW);
      run_command(ACT_NET, 1, LINE_HIGHISH);

      // Commands that land while busy must be dropped.
      configure(2, 1);
      data_mode = LINE_NOISE;
      send_tick(ACT_TARE, 1, line_level());
      send_tick(ACT_NET, 5, line_level());
      send_tick(ACT_AVERAGE, 0, line_level());
      command_mark = ticks_sent;
      settle();

      // Random phases: new settings between phases, random commands within.
      while (ticks_sent < ITEMS) begin
         configure($urandom_range(0, 3), $urandom_range(0, 2));
         goal = ticks_sent + $urandom_range(40, 120);
         while (ticks_sent < goal) begin
            calm = (ticks_sent >= ITEMS - 100);
            if ($urandom_range(0, 5) == 0) begin
               data_mode = $urandom_range(LINE_LOW, LINE_LOWISH);
               send_tick(ACT_TICK + ACT_W'($urandom_range(1, 3)), CNT_W'(pick_count()),
                         line_level());
               command_mark = ticks_sent;
            end else begin
               send_tick(ACT_TICK, CNT_W'($urandom_range(0, 255)), line_level());
            end
         end
         settle();
      end

      // Allow for the divider hold-off before the verdict.
      repeat (60) @(negedge clock);
      if (error_count == 0 && open_ticks == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Bound the run: far above the slowest legal schedule.
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
